@@ sv/lph_pkg.sv @@
// Shared types and constants for the linear probing hash set.
// Holds the request and response transaction structs and the opcode codes.
// Depends on nothing; every other file but lph_ram imports it.
package lph_pkg;

  localparam int KEY_FIELD_BITS    = 64;
  localparam int HASH_BITS         = 32;
  localparam int SLOT_BITS         = 8;
  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int KEY_BITS_DEF      = 64;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [KEY_FIELD_BITS-1:0] key_value;
    logic [HASH_BITS-1:0]      key_hash;
  } lph_req_t;

  typedef struct packed {
    logic                 success;
    logic                 table_full;
    logic [SLOT_BITS-1:0] slot_index;
  } lph_rsp_t;

endpackage

@@ sv/linear_probe_hash_set.sv @@
// Top level of the open-addressed hash set with linear probing and tombstones.
// Depends on lph_pkg, lph_ram for the slot store and lph_mod for the home slot.
//
// A transaction is taken when start is high and busy is low; its response
// appears on rsp for exactly one cycle with done high and cannot be held off.
// Slots are probed one per cycle from a single RAM read port. When the table
// depth is not a power of two, the home slot comes from a pipelined remainder
// unit. A clear answers at once and then sweeps the store, one slot a cycle,
// holding busy until every slot is written; the same sweep runs after reset.
module linear_probe_hash_set
  import lph_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  lph_req_t req,
  output logic     done,
  output lph_rsp_t rsp
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int WORD_W = KEY_BITS + HASH_BITS + 2;
  localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MOD   = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [1:0]           state;
  logic [1:0]           op;
  logic [KEY_BITS-1:0]  key;
  logic [HASH_BITS-1:0] hash;
  logic [IDX_W-1:0]     raddr, eval_addr, n, cand, clr_addr;
  logic                 rd_valid, have_cand;

  logic                 accept;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;

  logic                 mod_start, mod_done;
  logic [IDX_W-1:0]     mod_rem;

  logic                 slot_used, slot_tomb, is_match;
  logic [HASH_BITS-1:0] slot_hash;
  logic [KEY_BITS-1:0]  slot_key;
  logic                 fin, res_ok, res_full;
  logic [IDX_W-1:0]     res_slot, cand_next;
  logic                 have_cand_next;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;
  assign mod_start = accept && (req.opcode != OP_CLEAR) && !IS_POW2;

  lph_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  lph_mod #(
    .DIVISOR(TABLE_DEPTH)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.key_hash),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  assign slot_used = ram_rdata[WORD_W-1];
  assign slot_tomb = ram_rdata[WORD_W-2];
  assign slot_hash = ram_rdata[KEY_BITS +: HASH_BITS];
  assign slot_key  = ram_rdata[KEY_BITS-1:0];
  assign is_match  = slot_used && !slot_tomb && (slot_hash == hash) && (slot_key == key);

  always_comb begin
    fin            = 1'b0;
    res_ok         = 1'b0;
    res_full       = 1'b0;
    res_slot       = '0;
    ram_we         = 1'b0;
    ram_waddr      = eval_addr;
    ram_wdata      = {1'b1, 1'b0, hash, key};
    have_cand_next = have_cand;
    cand_next      = cand;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_PROBE && rd_valid) begin
      if (slot_tomb && slot_used && !have_cand) begin
        have_cand_next = 1'b1;
        cand_next      = eval_addr;
      end
      if (!slot_used) begin
        fin = 1'b1;
        if (op == OP_INSERT) begin
          ram_we    = 1'b1;
          ram_waddr = have_cand ? cand : eval_addr;
          res_ok    = 1'b1;
          res_slot  = ram_waddr;
        end
      end else if (is_match) begin
        fin = 1'b1;
        if (op == OP_LOOKUP) begin
          res_ok   = 1'b1;
          res_slot = eval_addr;
        end else if (op == OP_DELETE) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, 1'b1, slot_hash, slot_key};
          res_ok    = 1'b1;
          res_slot  = eval_addr;
        end
      end else if (n == LAST_IDX) begin
        fin = 1'b1;
        if (op == OP_INSERT && have_cand_next) begin
          ram_we    = 1'b1;
          ram_waddr = cand_next;
          res_ok    = 1'b1;
          res_slot  = cand_next;
        end else begin
          res_full = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op   <= req.opcode;
            key  <= req.key_value[KEY_BITS-1:0];
            hash <= req.key_hash;
            rd_valid  <= 1'b0;
            n         <= '0;
            have_cand <= 1'b0;
            if (req.opcode == OP_CLEAR) begin
              state    <= ST_CLEAR;
              clr_addr <= '0;
              done     <= 1'b1;
              rsp      <= '{success: 1'b1, table_full: 1'b0, slot_index: '0};
            end else if (IS_POW2) begin
              state <= ST_PROBE;
              raddr <= req.key_hash[IDX_W-1:0];
            end else begin
              state <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            state <= ST_PROBE;
            raddr <= mod_rem;
          end
        end
        ST_PROBE: begin
          rd_valid  <= 1'b1;
          eval_addr <= raddr;
          raddr     <= (raddr == LAST_IDX) ? '0 : raddr + 1'b1;
          if (rd_valid) begin
            n         <= n + 1'b1;
            have_cand <= have_cand_next;
            cand      <= cand_next;
          end
          if (fin) begin
            state <= ST_IDLE;
            done  <= 1'b1;
            rsp   <= '{success: res_ok, table_full: res_full,
                       slot_index: SLOT_BITS'(res_slot)};
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state != ST_IDLE)
    else $error("The slot store was written while no transaction was in progress.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("An accepted transaction did not raise busy.");

  a_ok_excludes_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.success && rsp.table_full))
    else $error("A response reported success and a full table together.");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.success) |-> rsp.slot_index == '0)
    else $error("A failed response carried a non-zero slot index.");

endmodule

@@ sv/lph_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot store of the hash set; no dependencies.
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lph_mod.sv @@
// Remainder of the 32-bit hash by a constant table depth, by reciprocal
// multiplication in a pipeline through the num, quo and rem registers; uses lph_pkg.
module lph_mod
  import lph_pkg::*;
#(
  parameter int DIVISOR = TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [HASH_BITS-1:0]       dividend,
  output logic                       done,
  output logic [$clog2(DIVISOR)-1:0] remainder
);

  localparam int RW    = $clog2(DIVISOR);
  localparam int SHIFT = HASH_BITS + RW;
  localparam int PW    = 2 * HASH_BITS;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [HASH_BITS:0]   RECIP = RECIP_WIDE[HASH_BITS:0];
  localparam logic [HASH_BITS-1:0] DIV_C = HASH_BITS'(DIVISOR);

  logic [HASH_BITS-1:0] num, quo, rem_full;
  logic [PW:0]          prod;
  logic [RW-1:0]        rem;
  logic                 num_valid, quo_valid;

  // The rounded-up reciprocal makes the truncated quotient exact for every
  // 32-bit hash.
  assign prod = {1'b0, PW'(num) * PW'(RECIP[HASH_BITS-1:0])} +
                (RECIP[HASH_BITS] ? {1'b0, num, {HASH_BITS{1'b0}}} : '0);
  assign rem_full = num - quo * DIV_C;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_valid <= 1'b0;
      quo_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      num_valid <= start;
      quo_valid <= num_valid;
      done      <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    quo <= HASH_BITS'(prod >> SHIFT);
    rem <= rem_full[RW-1:0];
  end

  assign remainder = rem;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for linear_probe_hash_set, the open-addressed hash set.
// Depends on lph_pkg and the RTL; a scoreboard class mirrors the slot table and
// checks every response, while plain tasks drive directed and random transactions.
`timescale 1ns / 1ps

module testbench;
  import lph_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int POOL_SIZE   = 16;

  class hash_set_tracker;
    bit [KEY_FIELD_BITS-1:0] slot_key  [DEPTH];
    bit [HASH_BITS-1:0]      slot_hash [DEPTH];
    bit                      slot_used [DEPTH];
    bit                      slot_tomb [DEPTH];
    lph_rsp_t                awaited_rsp [$];
    int                      mismatches;

    function void take_slot(int s, lph_req_t r);
      slot_key[s]  = r.key_value;
      slot_hash[s] = r.key_hash;
      slot_used[s] = 1'b1;
      slot_tomb[s] = 1'b0;
    endfunction

    function lph_rsp_t probe_outcome(lph_req_t r);
      lph_rsp_t o;
      int       s;
      int       cand;
      bit       have_cand;
      o         = '0;
      cand      = 0;
      have_cand = 1'b0;
      if (r.opcode == OP_CLEAR) begin
        foreach (slot_used[i]) begin
          slot_used[i] = 1'b0;
          slot_tomb[i] = 1'b0;
        end
        o.success = 1'b1;
        return o;
      end
      s = int'(r.key_hash % DEPTH);
      for (int n = 0; n < DEPTH; n++) begin
        if (!slot_used[s]) begin
          if (r.opcode == OP_INSERT) begin
            if (have_cand) s = cand;
            take_slot(s, r);
            o.success    = 1'b1;
            o.slot_index = 8'(s);
          end
          return o;
        end
        if (slot_tomb[s]) begin
          if (!have_cand) begin
            have_cand = 1'b1;
            cand      = s;
          end
        end else if (slot_hash[s] == r.key_hash && slot_key[s] == r.key_value) begin
          if (r.opcode != OP_INSERT) begin
            o.success    = 1'b1;
            o.slot_index = 8'(s);
          end
          if (r.opcode == OP_DELETE) slot_tomb[s] = 1'b1;
          return o;
        end
        s = (s + 1) % DEPTH;
      end
      if (r.opcode == OP_INSERT && have_cand) begin
        take_slot(cand, r);
        o.success    = 1'b1;
        o.slot_index = 8'(cand);
      end else begin
        o.table_full = 1'b1;
      end
      return o;
    endfunction

    function void note_request(lph_req_t r);
      awaited_rsp.push_back(probe_outcome(r));
    endfunction

    function void check_response(lph_rsp_t got);
      lph_rsp_t want;
      if (awaited_rsp.size() == 0) begin
        $error("response with no transaction outstanding: %p", got);
        mismatches++;
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.success !== want.success) begin
        $error("success: expected %0d, got %0d", want.success, got.success);
        mismatches++;
      end
      if (got.table_full !== want.table_full) begin
        $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
        mismatches++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  lph_req_t req;
  logic     done;
  lph_rsp_t rsp;

  hash_set_tracker tracker = new();
  int              quiet_cycles = 0;
  int              idle_pct = 21;
  logic [63:0]     pool_key  [POOL_SIZE];
  logic [31:0]     pool_hash [POOL_SIZE];

  linear_probe_hash_set u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (done) tracker.check_response(rsp);
      if (start && !busy) tracker.note_request(req);
      if (done || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [63:0] key,
                           input logic [31:0] hash);
    lph_req_t item;
    item.opcode    = op;
    item.key_value = key;
    item.key_hash  = hash;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_rsp.size() != 0) @(posedge clk);
  endtask

  // Keys cluster round a few home slots so that probe runs, duplicates and
  // deletes of live keys are frequent; some entries share a key or a hash.
  task automatic refill_pool(input int base);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i]       = {$urandom, $urandom};
      pool_hash[i]      = $urandom;
      pool_hash[i][7:0] = 8'((base + $urandom_range(0, 9)) % DEPTH);
      if (i % 4 == 3) pool_key[i] = pool_key[i-1];
      else if (i % 5 == 4) pool_hash[i] = pool_hash[i-1];
    end
  endtask

  initial begin : stimulus
    logic [63:0] fill_key  [DEPTH];
    logic [31:0] fill_hash [DEPTH];
    logic [63:0] k;
    logic [31:0] h;
    logic [1:0]  op;
    int          roll;
    int          p;

    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_LOOKUP, 64'h0, 32'h0);
    send_item(OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 64'h0123_4567_89AB_CDEF, 32'h1234_5640);
    send_item(OP_INSERT, 64'h0123_4567_89AB_CDEF, 32'h1234_5640);
    send_item(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'h1234_5640);
    send_item(OP_INSERT, 64'hFEDC_BA98_7654_3210, 32'hEDCB_A940);
    send_item(OP_INSERT, 64'h0123_4567_89AB_CDEF, 32'h0000_0040);
    send_item(OP_INSERT, 64'hFEDC_BA98_7654_3210, 32'h1234_5640);
    send_item(OP_LOOKUP, 64'hFEDC_BA98_7654_3210, 32'h1234_5640);
    send_item(OP_DELETE, 64'h0123_4567_89AB_CDEF, 32'h1234_5640);
    send_item(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'h1234_5640);
    send_item(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'h0000_0040);
    send_item(OP_DELETE, 64'h0123_4567_89AB_CDEF, 32'h1234_5640);
    send_item(OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AA41);
    send_item(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5540);
    send_item(OP_DELETE, 64'h0, 32'h0000_0041);
    send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 64'h0, 32'h0000_00FF);
    send_item(OP_LOOKUP, 64'h0, 32'h0000_00FF);
    send_item(OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 64'h0, 32'h0000_00FF);
    send_item(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'h1234_5640);
    send_item(OP_INSERT, 64'h0, 32'h0);
    send_item(OP_LOOKUP, 64'h0, 32'h0);
    drain();

    // Fill every slot, then exercise probes that wrap the whole table.
    for (int i = 0; i < DEPTH; i++) begin
      fill_key[i]  = {$urandom, $urandom};
      fill_hash[i] = $urandom;
      send_item(OP_INSERT, fill_key[i], fill_hash[i]);
    end
    send_item(OP_INSERT, 64'h0, 32'h0);
    send_item(OP_LOOKUP, {$urandom, $urandom}, $urandom);
    send_item(OP_DELETE, {$urandom, $urandom}, $urandom);
    send_item(OP_INSERT, {$urandom, $urandom}, $urandom);
    send_item(OP_LOOKUP, fill_key[17], fill_hash[17]);
    send_item(OP_DELETE, fill_key[40], fill_hash[40]);
    k = {$urandom, $urandom};
    h = $urandom;
    send_item(OP_INSERT, k, h);
    send_item(OP_LOOKUP, k, h);
    send_item(OP_LOOKUP, fill_key[40], fill_hash[40]);
    send_item(OP_CLEAR, 64'h0, 32'h0);

    for (int i = 0; i < 250; i++) begin
      if (i % 60 == 0) refill_pool((i == 120) ? 250 : $urandom_range(0, DEPTH - 1));
      idle_pct = (i >= 60 && i < 150) ? 0 : 21;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_item(OP_CLEAR, {$urandom, $urandom}, $urandom);
      end else if (roll < 8) begin
        op = (roll < 4) ? OP_LOOKUP : (roll < 6) ? OP_INSERT : OP_DELETE;
        send_item(op, {$urandom, $urandom}, $urandom);
      end else begin
        p    = $urandom_range(0, POOL_SIZE - 1);
        roll = $urandom_range(0, 99);
        op   = (roll < 45) ? OP_INSERT : (roll < 75) ? OP_LOOKUP : OP_DELETE;
        send_item(op, pool_key[p], pool_hash[p]);
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (tracker.awaited_rsp.size() != 0)
        $error("%0d responses never arrived", tracker.awaited_rsp.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lph_pkg.sv
sv/lph_ram.sv
sv/lph_mod.sv
sv/linear_probe_hash_set.sv
dv/testbench.sv
